// ===== hdl/scbr_pkg.sv =====
// ----------------------------------------------------------------------------
// scbr_pkg: shared types for the size-class block recycler
// Result status codes, back-end state codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package scbr_pkg;

  localparam int unsigned HandleW = 64;
  localparam int unsigned ClassW  = 13;
  localparam int unsigned BytesW  = 48;
  localparam int unsigned GrantW  = 49;
  localparam int unsigned LimitW  = 20;

  typedef enum logic [2:0] {
    ST_BUCKET  = 3'd0,
    ST_SINK    = 3'd1,
    ST_NEW     = 3'd2,
    ST_KEPT    = 3'd3,
    ST_RELEASE = 3'd4
  } status_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic               is_free;
    logic [HandleW-1:0] handle;
    logic [35:0]        cls;      // allocate: rounded units minus one; free: class
    logic [GrantW-1:0]  grant;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_HIGH,
    BK_SINK,
    BK_SHIFT,
    BK_RDWAIT,
    BK_DONE
  } bk_state_e;

endpackage

// ===== hdl/scbr_ram.sv =====
// ----------------------------------------------------------------------------
// scbr_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module scbr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/scbr_front.sv =====
// ----------------------------------------------------------------------------
// scbr_front: request classifier
// Rounds allocate sizes to units and builds the queue entry.
// ----------------------------------------------------------------------------
module scbr_front #(
  parameter int unsigned UnitShift = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      mode_i,
  input  logic [47:0]               request_bytes_i,
  input  logic [63:0]               block_handle_i,
  input  logic [12:0]               block_class_i,
  output logic                      busy_o,
  output logic                      push_o,
  output scbr_pkg::cmd_t            cmd_o,
  input  logic                      full_i
);
  import scbr_pkg::*;
  localparam int unsigned UnitsW = GrantW - UnitShift;

  logic [GrantW-1:0] size_up;
  logic [UnitsW-1:0] units;
  logic [UnitsW-1:0] units_fl;
  logic              valid_q, valid_d;
  cmd_t              cmd_q, cmd_d;

  always_comb begin
    size_up  = ({1'b0, request_bytes_i} + {{(GrantW-UnitShift){1'b0}}, {UnitShift{1'b1}}});
    units    = size_up[GrantW-1:UnitShift];
    units_fl = (units < UnitsW'(2)) ? UnitsW'(2) : units;
    cmd_d    = cmd_q;
    valid_d  = valid_q && full_i;
    if (start_i && !busy_o) begin
      valid_d       = 1'b1;
      cmd_d.is_free = mode_i;
      cmd_d.handle  = block_handle_i;
      if (mode_i) begin
        cmd_d.cls   = 36'(block_class_i);
        cmd_d.grant = '0;
      end else begin
        cmd_d.cls   = 36'(units_fl - UnitsW'(1));
        cmd_d.grant = {units_fl, {UnitShift{1'b0}}};
      end
    end
  end

  assign busy_o = valid_q && full_i;
  assign push_o = valid_q && !full_i;
  assign cmd_o  = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end
  always_ff @(posedge clk_i) cmd_q <= cmd_d;
endmodule

// ===== hdl/scbr_queue.sv =====
// ----------------------------------------------------------------------------
// scbr_queue: two-entry command queue
// Decouples the classifier from the back end.
// ----------------------------------------------------------------------------
module scbr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scbr_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output scbr_pkg::cmd_t data_o
);
  import scbr_pkg::*;
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ===== hdl/scbr_back.sv =====
// ----------------------------------------------------------------------------
// scbr_back: bucket and sink engine
// Scans buckets or the sink one entry a cycle and updates the store.
// ----------------------------------------------------------------------------
module scbr_back #(
  parameter int unsigned NumClasses  = 20,
  parameter int unsigned BucketDepth = 16,
  parameter int unsigned SinkDepth   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  scbr_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  logic [19:0]    limit_i,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic [63:0]    out_handle_o,
  output logic [12:0]    out_class_o,
  output logic [48:0]    grant_bytes_o
);
  import scbr_pkg::*;
  localparam int unsigned CiW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int unsigned CnW = $clog2(BucketDepth + 1);
  localparam int unsigned SnW = $clog2(SinkDepth + 1);
  localparam int unsigned SiW = (SinkDepth > 1) ? $clog2(SinkDepth) : 1;
  localparam int unsigned BaW = $clog2(NumClasses * BucketDepth);

  bk_state_e state_q, state_d;
  logic [CnW-1:0] cnt_q [NumClasses];
  logic [SnW-1:0] scnt_q;
  logic [CiW-1:0] high_q;
  logic [19:0]    budget_q;
  logic [CiW-1:0] idx_q;
  logic [SnW-1:0] sidx_q;
  logic [2:0]     st_q;
  logic [63:0]    h_q;
  logic [12:0]    c_q;
  logic [48:0]    g_q;
  logic           from_ram_q;
  logic           shift_first_q;

  logic [12:0] sclass_q [SinkDepth];  // small, read at the scan index and the index above it via mux
  logic           bwe, swe;
  logic [BaW-1:0] bwaddr, braddr;
  logic [SiW-1:0] swaddr, sraddr;
  logic [63:0]    bwdata, swdata, brdata, srdata;

  // handle store for buckets and sink
  scbr_ram #(.Width(64), .Depth(NumClasses * BucketDepth)) u_bram (
    .clk_i, .we_i(bwe), .waddr_i(bwaddr), .wdata_i(bwdata),
    .raddr_i(braddr), .rdata_o(brdata));
  scbr_ram #(.Width(64), .Depth(SinkDepth)) u_sram (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(swdata),
    .raddr_i(sraddr), .rdata_o(srdata));

  function automatic logic [BaW-1:0] baddr(logic [CiW-1:0] c, logic [CnW-1:0] e);
    baddr = BaW'(c * BucketDepth) + BaW'(e);
  endfunction

  logic [20:0] grow_sum;
  logic [20:0] need;
  logic [35:0] cls;
  logic        free_big;
  logic [CiW-1:0] fc;
  logic [12:0] sc_cur;

  always_comb begin
    cls      = cmd_i.cls;
    free_big = cls >= 36'(NumClasses);
    fc       = CiW'(cls);
    need     = 21'(cls[12:0]) + 21'd1;
    sc_cur   = sclass_q[SiW'(sidx_q)];
    grow_sum = 21'(budget_q) + 21'(c_q) + 21'd1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!empty_i) begin
        if (cmd_i.is_free) state_d = BK_DONE;
        else if (cls <= 36'(high_q)) state_d = BK_SCAN;
        else if (scnt_q != '0 && cls <= 36'd8191) state_d = BK_SINK;
        else state_d = BK_DONE;
      end
      BK_SCAN: begin
        if (cnt_q[idx_q] != '0) state_d = (cnt_q[idx_q] == CnW'(1) && idx_q == high_q)
                                          ? BK_HIGH : BK_RDWAIT;
        else if (idx_q == high_q || 32'(idx_q) == NumClasses - 1) state_d = BK_DONE;
      end
      BK_HIGH: if (idx_q == '0 || cnt_q[idx_q - CiW'(1)] != '0) state_d = BK_RDWAIT;
      BK_SINK: begin
        if (36'(sc_cur) >= cls) state_d = BK_SHIFT;
        else if (sidx_q == scnt_q - SnW'(1)) state_d = BK_DONE;
      end
      BK_SHIFT: if (sidx_q == scnt_q - SnW'(1)) state_d = BK_RDWAIT;
      BK_RDWAIT: state_d = BK_DONE;
      BK_DONE: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    bwe = 1'b0; swe = 1'b0;
    bwaddr = baddr(fc, cnt_q[fc]);
    bwdata = cmd_i.handle;
    braddr = baddr(idx_q, cnt_q[idx_q] - CnW'(1));
    swaddr = SiW'(sidx_q);
    swdata = srdata;
    sraddr = SiW'(sidx_q);
    // count already dropped: it now points at the popped entry
    if (state_q == BK_HIGH || state_q == BK_RDWAIT)
      braddr = baddr(CiW'(c_q), cnt_q[CiW'(c_q)]);
    // first shift cycle sees the hit handle; later ones move entry k down to k-1
    if (state_q == BK_SHIFT) begin
      sraddr = SiW'(sidx_q + SnW'(1));
      swe    = !shift_first_q;
      swaddr = SiW'(sidx_q - SnW'(1));
    end
    if (state_q == BK_DONE && cmd_i.is_free && st_q == ST_KEPT) begin
      if (free_big) begin
        swe = 1'b1; swaddr = SiW'(scnt_q); swdata = cmd_i.handle;
      end else bwe = 1'b1;
    end
  end

  assign pop_o         = state_q == BK_DONE;
  assign done_o        = state_q == BK_DONE;
  assign status_o      = st_q;
  assign out_handle_o  = from_ram_q ? (st_q == ST_SINK ? h_q : brdata) : h_q;
  assign out_class_o   = c_q;
  assign grant_bytes_o = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      for (int i = 0; i < NumClasses; i++) cnt_q[i] <= '0;
      scnt_q   <= '0;
      high_q   <= '0;
      budget_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_SCAN: if (state_d != BK_SCAN && cnt_q[idx_q] != '0)
          cnt_q[idx_q] <= cnt_q[idx_q] - CnW'(1);
        BK_HIGH: if (state_d == BK_RDWAIT) high_q <= (idx_q == '0) ? '0 : idx_q - CiW'(1);
        BK_SHIFT: if (state_d == BK_RDWAIT) scnt_q <= scnt_q - SnW'(1);
        BK_RDWAIT: budget_q <= (limit_i == '0) ? '0 :
                               (grow_sum > 21'(limit_i)) ? limit_i : grow_sum[19:0];
        BK_DONE: if (cmd_i.is_free && st_q == ST_KEPT) begin
          budget_q <= (21'(budget_q) >= need) ? 20'(21'(budget_q) - need) : '0;
          if (free_big) scnt_q <= scnt_q + SnW'(1);
          else begin
            cnt_q[fc] <= cnt_q[fc] + CnW'(1);
            if (cnt_q[fc] == '0 && fc > high_q) high_q <= fc;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, including sink class shift
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        idx_q <= fc; sidx_q <= '0; from_ram_q <= 1'b0;
        h_q <= '0; g_q <= '0;
        if (cmd_i.is_free) begin
          if ((limit_i != '0 && need > 21'(budget_q)) ||
              (free_big ? scnt_q >= SnW'(SinkDepth) : cnt_q[fc] >= CnW'(BucketDepth))) begin
            st_q <= ST_RELEASE; h_q <= cmd_i.handle; c_q <= cls[12:0];
          end else begin
            st_q <= ST_KEPT; c_q <= '0;
          end
        end else begin
          st_q <= ST_NEW; g_q <= cmd_i.grant;
          c_q  <= (cls > 36'd8191) ? 13'h1FFF : cls[12:0];
        end
      end
      BK_SCAN: if (cnt_q[idx_q] != '0) begin
        st_q <= ST_BUCKET; c_q <= 13'(idx_q); g_q <= '0; from_ram_q <= 1'b1;
      end else if (state_d == BK_SCAN) idx_q <= idx_q + CiW'(1);
      BK_HIGH: if (state_d == BK_HIGH) idx_q <= idx_q - CiW'(1);
      BK_SINK: if (36'(sc_cur) >= cls) begin
        st_q <= ST_SINK; c_q <= sc_cur; g_q <= '0; from_ram_q <= 1'b1;
        shift_first_q <= 1'b1;
      end else if (state_d == BK_SINK) sidx_q <= sidx_q + SnW'(1);
      BK_SHIFT: begin
        shift_first_q <= 1'b0;
        if (shift_first_q) h_q <= srdata;
        if (sraddr == SiW'(sidx_q + SnW'(1)) && sidx_q != scnt_q - SnW'(1)) begin
          sclass_q[SiW'(sidx_q)] <= sclass_q[SiW'(sidx_q + SnW'(1))];
        end
        sidx_q <= sidx_q + SnW'(1);
      end
      BK_DONE: if (cmd_i.is_free && st_q == ST_KEPT && free_big)
        sclass_q[SiW'(scnt_q)] <= cls[12:0];
      default: ;
    endcase
  end
endmodule

// ===== hdl/size_class_block_recycler.sv =====
// ----------------------------------------------------------------------------
// size_class_block_recycler: top level
// Recycles freed memory blocks by size class.
// ----------------------------------------------------------------------------
// channel   | signals                                   | handshake
// request   | start_i, mode_i, request_bytes_i, ...      | start_i && !busy_o
// result    | done_o, status_o, out_handle_o, ...        | done_o, one cycle
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i       | valid && ready
// A free, or an allocate that goes straight to allocate-new, passes in the back
// end from idle directly to done. A bucket hit adds the scan (one bucket a cycle)
// and, when the top bucket empties, a walk down for the new mark. A sink hit
// adds the sink scan and the shift.
// Reset clears counts, marks and budget; handle RAMs are not cleared.
// The result receiver cannot stall; busy_o rises only when the queue is full.
// ----------------------------------------------------------------------------
module size_class_block_recycler #(
  parameter int unsigned NumClasses  = 20,
  parameter int unsigned BucketDepth = 16,
  parameter int unsigned SinkDepth   = 16,
  parameter int unsigned UnitShift   = 23
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [47:0] request_bytes_i,
  input  logic [63:0] block_handle_i,
  input  logic [12:0] block_class_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] out_handle_o,
  output logic [12:0] out_class_o,
  output logic [48:0] grant_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);
  import scbr_pkg::*;
  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;
  logic [19:0] limit_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= '0;
    else if (cfg_valid_i) limit_q <= cfg_data_i;
  end

  scbr_front #(.UnitShift(UnitShift)) u_front (
    .clk_i, .rst_ni, .start_i, .mode_i, .request_bytes_i, .block_handle_i,
    .block_class_i, .busy_o, .push_o(push), .cmd_o(push_cmd), .full_i(full));
  scbr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_cmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(head_cmd));
  scbr_back #(.NumClasses(NumClasses), .BucketDepth(BucketDepth),
              .SinkDepth(SinkDepth)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(head_cmd), .pop_o(pop),
    .limit_i(limit_q), .done_o, .status_o, .out_handle_o, .out_class_o,
    .grant_bytes_o);
endmodule

// ===== hdl/scbr_checker.sv =====
// ----------------------------------------------------------------------------
// scbr_checker: port-level assertions
// Checks result encoding and that done_o drops after each result on the top-level ports.
// ----------------------------------------------------------------------------
module scbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [63:0] out_handle_o,
  input logic [12:0] out_class_o,
  input logic [48:0] grant_bytes_o
);
  import scbr_pkg::*;
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= 3'(ST_RELEASE)) else $error("bad status");
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == 3'(ST_KEPT) |-> out_handle_o == '0 && out_class_o == '0)
    else $error("kept carries data");
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != 3'(ST_NEW) |-> grant_bytes_o == '0) else $error("grant");
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result not one cycle");
endmodule

bind size_class_block_recycler scbr_checker u_scbr_checker (.*);
